// File: design/modbus_rtu_frame_receiver_macros.svh
// Assertion macros for the Modbus RTU frame receiver checker.
// No dependencies; expects signals clk and rst in the including scope.
`ifndef MODBUS_RTU_FRAME_RECEIVER_MACROS_SVH
`define MODBUS_RTU_FRAME_RECEIVER_MACROS_SVH

// checked outside reset
`define MBRTU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define MBRTU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/mbrtu_pkg.sv
// Shared types and constants for the Modbus RTU frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package mbrtu_pkg;

  localparam int CNT_W = 9;

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [1:0] STATUS_IDLE    = 2'd0;
  localparam logic [1:0] STATUS_DONE    = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_POLY       = 2'd2;

  localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
  localparam logic [15:0] TIMEOUT_RST    = 16'd100;
  localparam logic [15:0] POLY_RST       = 16'hA001;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;

  localparam logic [7:0] FUNC_READ_COILS   = 8'h01;
  localparam logic [7:0] FUNC_READ_HOLD    = 8'h03;
  localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FUNC_WRITE_MULTI  = 8'h10;

  localparam logic [CNT_W-1:0] POS_FUNC       = 9'd1;
  localparam logic [CNT_W-1:0] POS_BYTE_COUNT = 9'd6;
  localparam logic [CNT_W-1:0] FIXED_LEN      = 9'd8;
  localparam logic [CNT_W-1:0] MULTI_OVERHEAD = 9'd9;

  // packed MSB first: byte_stored ends up in bit 0
  typedef struct packed {
    logic [7:0]       function_code;
    logic [CNT_W-1:0] frame_length;
    logic [1:0]       frame_status;
    logic [7:0]       byte_position;
    logic             byte_stored;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

// File: design/mbrtu_crc8.sv
// Byte-wide reflected CRC-16 update, eight unrolled shift steps.
// Purely combinational; no package dependency.
`timescale 1ns / 1ps

module mbrtu_crc8 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  input  logic [15:0] poly,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] r;
    r = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ poly;
      end else begin
        r = r >> 1;
      end
    end
    crc_out = r;
  end

endmodule

// File: design/mbrtu_core.sv
// Frame state, configuration registers and per-transfer result logic.
// Depends on mbrtu_pkg and mbrtu_crc8.
`timescale 1ns / 1ps

module mbrtu_core import mbrtu_pkg::*; #(
  parameter int FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        op,
  input  logic [7:0]  data_byte,
  output result_t     result
);

  localparam logic [CNT_W-1:0] FRAME_LIMIT = CNT_W'(FRAME_BYTES);

  logic [7:0]       slave_address;
  logic [15:0]      timeout_ticks;
  logic [15:0]      crc_polynomial;

  logic             receiving, receiving_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic [15:0]      crc_residue, crc_residue_next;
  logic [7:0]       function_byte, function_byte_next;
  logic [7:0]       byte_count_field, byte_count_field_next;
  logic [15:0]      silence_counter, silence_counter_next;

  logic [15:0]      crc_base;
  logic [15:0]      crc_fold;
  logic             fixed_func;
  logic             done;
  logic             stored;
  logic [7:0]       pos;
  logic [1:0]       status;

  assign crc_base = receiving ? crc_residue : CRC_INIT;

  mbrtu_crc8 u_crc (
    .crc_in  (crc_base),
    .data    (data_byte),
    .poly    (crc_polynomial),
    .crc_out (crc_fold)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address  <= SLAVE_ADDR_RST;
      timeout_ticks  <= TIMEOUT_RST;
      crc_polynomial <= POLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLAVE_ADDR: slave_address  <= cfg_data[7:0];
        REG_TIMEOUT:    timeout_ticks  <= cfg_data;
        REG_POLY:       crc_polynomial <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    receiving_next        = receiving;
    stored_count_next     = stored_count;
    crc_residue_next      = crc_residue;
    function_byte_next    = function_byte;
    byte_count_field_next = byte_count_field;
    silence_counter_next  = silence_counter;
    stored                = 1'b0;
    pos                   = 8'd0;
    status                = STATUS_IDLE;
    fixed_func            = 1'b0;
    done                  = 1'b0;

    if (in_valid) begin
      if (op == OP_BYTE) begin
        if (!receiving) begin
          if (data_byte == slave_address) begin
            crc_residue_next      = crc_fold;
            stored_count_next     = CNT_W'(1);
            function_byte_next    = 8'd0;
            byte_count_field_next = 8'd0;
            silence_counter_next  = timeout_ticks;
            receiving_next        = 1'b1;
            stored                = 1'b1;
          end
        end else begin
          if (stored_count < FRAME_LIMIT) begin
            pos              = stored_count[7:0];
            crc_residue_next = crc_fold;
            if (stored_count == POS_FUNC) begin
              function_byte_next = data_byte;
            end
            if (stored_count == POS_BYTE_COUNT) begin
              byte_count_field_next = data_byte;
            end
            stored_count_next    = stored_count + CNT_W'(1);
            silence_counter_next = timeout_ticks;
            stored               = 1'b1;
          end
          fixed_func = (function_byte_next == FUNC_READ_COILS)
                    || (function_byte_next == FUNC_READ_HOLD)
                    || (function_byte_next == FUNC_WRITE_SINGLE);
          done = (crc_residue_next == 16'd0)
              && ((fixed_func && stored_count_next == FIXED_LEN)
               || (function_byte_next == FUNC_WRITE_MULTI
                && stored_count_next == {1'b0, byte_count_field_next} + MULTI_OVERHEAD));
          if (done) begin
            receiving_next       = 1'b0;
            silence_counter_next = 16'd0;
            status               = STATUS_DONE;
          end
        end
      end else if (receiving && silence_counter != 16'd0) begin
        silence_counter_next = silence_counter - 16'd1;
        if (silence_counter_next == 16'd0) begin
          receiving_next = 1'b0;
          status         = STATUS_TIMEOUT;
        end
      end
    end

    result.byte_stored   = stored;
    result.byte_position = pos;
    result.frame_status  = status;
    result.frame_length  = stored_count_next;
    result.function_code = function_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving        <= 1'b0;
      stored_count     <= '0;
      crc_residue      <= CRC_INIT;
      function_byte    <= 8'd0;
      byte_count_field <= 8'd0;
      silence_counter  <= 16'd0;
    end else begin
      receiving        <= receiving_next;
      stored_count     <= stored_count_next;
      crc_residue      <= crc_residue_next;
      function_byte    <= function_byte_next;
      byte_count_field <= byte_count_field_next;
      silence_counter  <= silence_counter_next;
    end
  end

endmodule

// File: design/mbrtu_skid.sv
// Output register with one skid entry; input ready comes from a flop.
// Depends on mbrtu_pkg.
`timescale 1ns / 1ps

module mbrtu_skid import mbrtu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else if (!in_valid) begin
          out_valid <= 1'b0;
        end
      end else if (!out_valid) begin
        out_valid <= in_valid;
      end else if (in_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (!out_valid) begin
      out_data <= in_data;
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

// File: design/modbus_rtu_frame_receiver.sv
// Each result is registered in the output register, via the skid entry if m_tready is low.
// Throughput: one transfer per cycle while s_tready is high; the byte-wide CRC
// update and the frame check sit between the state registers and the output register.
// s_tready drops only while the skid entry holds a result.
// Reset (rst, synchronous): idle, CRC 0xFFFF, counters zero, registers at defaults.
// Depends on mbrtu_pkg, mbrtu_core, mbrtu_skid.
`timescale 1ns / 1ps

module modbus_rtu_frame_receiver import mbrtu_pkg::*; #(
  parameter int FRAME_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // data_byte
  input  logic               s_tuser,   // op
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata    // byte_stored, byte_position, frame_status,
                                        // frame_length, function_code, zero fill
);

  logic    accept;
  result_t core_result;
  result_t out_result;

  assign accept = s_tvalid && s_tready;

  mbrtu_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (accept),
    .op        (s_tuser),
    .data_byte (s_tdata),
    .result    (core_result)
  );

  mbrtu_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_data   (core_result),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = TDATA_W'(out_result);

endmodule

// File: design/mbrtu_checker.sv
// Port-level checks for the Modbus RTU frame receiver, bound to the top level.
// Depends on mbrtu_pkg and modbus_rtu_frame_receiver_macros.svh.
`timescale 1ns / 1ps
`include "modbus_rtu_frame_receiver_macros.svh"

module mbrtu_checker import mbrtu_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata
);

  result_t res;
  logic    out_unstored;
  logic    out_timeout;

  assign res          = m_tdata[RESULT_W-1:0];
  assign out_unstored = m_tvalid && !res.byte_stored;
  assign out_timeout  = m_tvalid && (res.frame_status == STATUS_TIMEOUT);

  `MBRTU_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")
  `MBRTU_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output changed")
  `MBRTU_ASSERT(a_stall_full, s_tvalid && !s_tready |-> m_tvalid, "input stalled while empty")
  `MBRTU_ASSERT(a_pos_unstored, out_unstored |-> res.byte_position == 8'd0, "stray position")
  `MBRTU_ASSERT(a_timeout_tick, out_timeout |-> !res.byte_stored, "timeout on stored byte")

endmodule

bind modbus_rtu_frame_receiver mbrtu_checker u_mbrtu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
